>>> src/lzr_pkg.sv
// shared types and constants for the lz77 / run-length byte decompressor
package lzr_pkg;

  localparam int WIN_AW    = 12;
  localparam int WIN_DEPTH = 1 << WIN_AW;
  localparam int LEN_W     = 5;

  localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;
  localparam logic [7:0]       FLAG_FIRST = 8'h01;

  // window memory access from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [WIN_AW-1:0] raddr;
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
  } win_req_t;

  // one decompressed result word
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [6:0] rep;
    logic       last;
  } res_t;

endpackage

>>> src/lzr_window_ram.sv
// 4096 x 8 history window with registered read and clearing pass after reset
module lzr_window_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  lzr_pkg::win_req_t req,
  output logic [7:0]        rdata,
  output logic              busy
);

  localparam int AW = lzr_pkg::WIN_AW;

  logic [7:0]                mem [lzr_pkg::WIN_DEPTH];
  logic [lzr_pkg::WIN_AW-1:0] clr_addr_r;
  logic                      busy_r;
  logic [7:0]                rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == {lzr_pkg::WIN_AW{1'b1}}) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= 8'h00;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

>>> src/lzr_out_buf.sv
// output register between the decoder and the result stream
module lzr_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  lzr_pkg::res_t push,
  output logic          can_push,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,
  output logic          out_tlast
);

  logic       valid_r;
  logic [7:0] data_r;
  logic [6:0] rep_r;
  logic       last_r;

  assign can_push = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push.valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      data_r <= push.data;
      rep_r  <= push.rep;
      last_r <= push.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, rep_r, data_r};
  assign out_tlast  = last_r;

endmodule

>>> src/lz77_rle_byte_decompressor_core.sv
// top level: lz77 window decoder with run-length expansion
//
//  channel | direction | signals                         | word
//  --------+-----------+---------------------------------+---------------------------------
//  in_     | sink      | in_tvalid in_tready in_tdata    | tdata[7:0] data_byte,
//          |           | in_tlast                        | tlast end_of_stream
//  out_    | source    | out_tvalid out_tready out_tdata | tdata[7:0] out_byte,
//          |           | out_tlast                       | [14:8] repeat_count, tlast last
//  cfg_    | sink      | cfg_valid cfg_ready cfg_data    | pack_method, always ready
//
// after reset the window is zeroed one entry a cycle, with in_tready low meanwhile
// a literal, flag byte or pair low byte is taken in ST_IDLE; a pair high byte starts
// a window copy through ST_RD and ST_WR, each copied byte being a window read then a write
// the last result of a word is held until the word ends so it can carry tlast
// a stalled out_ side holds the sequencer; only one result buffer sits on out_
module lz77_rle_byte_decompressor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [14:8] repeat_count, [15] zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  localparam int AW = lzr_pkg::WIN_AW;
  localparam int LW = lzr_pkg::LEN_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RD    = 4'b0010,
    ST_WR    = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  typedef struct packed {
    logic       emit;
    logic [6:0] rep;
    logic [7:0] run;
  } rle_t;

  // run-length stage: header byte, repeat, or pass-through
  function automatic rle_t rle_step(input logic en, input logic [7:0] run,
                                    input logic [7:0] v);
    rle_t r;
    r.emit = 1'b1;
    r.rep  = 7'd1;
    r.run  = run;
    if (en) begin
      if (run[6:0] != 7'd0) begin
        if (run[7]) begin
          r.run = run - 8'd1;
        end else begin
          r.rep = run[6:0];
          r.run = 8'h00;
        end
      end else begin
        r.emit = 1'b0;
        r.run  = v;
      end
    end
    return r;
  endfunction

  state_t          state_r, state_nxt;
  logic [1:0]      pack_r;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [7:0]      flag_bits_r, flag_bits_nxt;
  logic [7:0]      flag_mask_r, flag_mask_nxt;
  logic [7:0]      pair_lo_r, pair_lo_nxt;
  logic            pair_pend_r, pair_pend_nxt;
  logic [7:0]      run_r, run_nxt;
  logic [AW-1:0]   src_r, src_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic            eos_r, eos_nxt;
  logic            hold_valid_r, hold_valid_nxt;
  logic [7:0]      hold_data_r, hold_data_nxt;
  logic [6:0]      hold_rep_r, hold_rep_nxt;

  lzr_pkg::win_req_t win_req;
  lzr_pkg::res_t     push;
  logic [7:0]        win_rdata;
  logic              win_busy;
  logic              can_push;
  logic              in_fire;
  logic [15:0]       pair_word;
  rle_t              rle_in, rle_win;

  lzr_window_ram u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (win_req),
    .rdata (win_rdata),
    .busy  (win_busy)
  );

  lzr_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .can_push   (can_push),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE) && !win_busy && can_push;
  assign in_fire   = in_tvalid && in_tready;
  assign pair_word = {in_tdata, pair_lo_r};
  assign rle_in    = rle_step(pack_r[0], run_r, in_tdata);
  assign rle_win   = rle_step(pack_r[0], run_r, win_rdata);

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    flag_bits_nxt  = flag_bits_r;
    flag_mask_nxt  = flag_mask_r;
    pair_lo_nxt    = pair_lo_r;
    pair_pend_nxt  = pair_pend_r;
    run_nxt        = run_r;
    src_nxt        = src_r;
    cnt_nxt        = cnt_r;
    eos_nxt        = eos_r;
    hold_valid_nxt = hold_valid_r;
    hold_data_nxt  = hold_data_r;
    hold_rep_nxt   = hold_rep_r;
    win_req        = '0;
    push           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!pack_r[1]) begin
            // lz off: byte goes straight to the run-length stage
            run_nxt    = rle_in.run;
            push.valid = rle_in.emit;
            push.data  = in_tdata;
            push.rep   = rle_in.rep;
            push.last  = 1'b1;
          end else if (pair_pend_r) begin
            // high byte of a pair: start the window copy
            cnt_nxt       = LW'(pair_word[15:12]) + lzr_pkg::LEN_BIAS;
            src_nxt       = wp_r - pair_word[AW-1:0] - AW'(1);
            pair_pend_nxt = 1'b0;
            pair_lo_nxt   = 8'h00;
            flag_mask_nxt = flag_mask_r << 1;
            eos_nxt       = in_tlast;
            state_nxt     = ST_RD;
          end else if (flag_mask_r == 8'h00) begin
            flag_bits_nxt = in_tdata;
            flag_mask_nxt = lzr_pkg::FLAG_FIRST;
          end else if ((flag_bits_r & flag_mask_r) != 8'h00) begin
            // low byte of a pair, dropped when cut off by end of stream
            if (!in_tlast) begin
              pair_lo_nxt   = in_tdata;
              pair_pend_nxt = 1'b1;
            end
          end else begin
            // literal
            win_req.we    = 1'b1;
            win_req.waddr = wp_r;
            win_req.wdata = in_tdata;
            wp_nxt        = wp_r + AW'(1);
            flag_mask_nxt = flag_mask_r << 1;
            run_nxt       = rle_in.run;
            push.valid    = rle_in.emit;
            push.data     = in_tdata;
            push.rep      = rle_in.rep;
            push.last     = 1'b1;
          end
          if (in_tlast && !(pack_r[1] && pair_pend_r)) begin
            wp_nxt        = '0;
            flag_bits_nxt = 8'h00;
            flag_mask_nxt = 8'h00;
            pair_lo_nxt   = 8'h00;
            pair_pend_nxt = 1'b0;
            run_nxt       = 8'h00;
          end
        end
      end

      ST_RD: begin
        win_req.rd_en = 1'b1;
        win_req.raddr = src_r;
        state_nxt     = ST_WR;
      end

      ST_WR: begin
        // a new result pushes out the held one; wait if the buffer is full
        if (!(rle_win.emit && hold_valid_r && !can_push)) begin
          win_req.we    = 1'b1;
          win_req.waddr = wp_r;
          win_req.wdata = win_rdata;
          wp_nxt        = wp_r + AW'(1);
          src_nxt       = src_r + AW'(1);
          cnt_nxt       = cnt_r - LW'(1);
          run_nxt       = rle_win.run;
          if (rle_win.emit) begin
            push.valid     = hold_valid_r;
            push.data      = hold_data_r;
            push.rep       = hold_rep_r;
            push.last      = 1'b0;
            hold_valid_nxt = 1'b1;
            hold_data_nxt  = win_rdata;
            hold_rep_nxt   = rle_win.rep;
          end
          state_nxt = (cnt_r == LW'(1)) ? ST_FLUSH : ST_RD;
        end
      end

      ST_FLUSH: begin
        if (!hold_valid_r || can_push) begin
          push.valid     = hold_valid_r;
          push.data      = hold_data_r;
          push.rep       = hold_rep_r;
          push.last      = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
          if (eos_r) begin
            wp_nxt        = '0;
            flag_bits_nxt = 8'h00;
            flag_mask_nxt = 8'h00;
            pair_lo_nxt   = 8'h00;
            pair_pend_nxt = 1'b0;
            run_nxt       = 8'h00;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pack_r       <= 2'b00;
      wp_r         <= '0;
      flag_bits_r  <= 8'h00;
      flag_mask_r  <= 8'h00;
      pair_lo_r    <= 8'h00;
      pair_pend_r  <= 1'b0;
      run_r        <= 8'h00;
      eos_r        <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flag_mask_r  <= flag_mask_nxt;
      pair_lo_r    <= pair_lo_nxt;
      pair_pend_r  <= pair_pend_nxt;
      run_r        <= run_nxt;
      eos_r        <= eos_nxt;
      hold_valid_r <= hold_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        pack_r <= cfg_data;
      end
    end
  end

  // copy pointers and held result carry payload only
  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    cnt_r       <= cnt_nxt;
    hold_data_r <= hold_data_nxt;
    hold_rep_r  <= hold_rep_nxt;
  end

endmodule

>>> verif/testbench.sv
// self-checking bench for the lz77 / run-length byte decompressor core
`timescale 1ns / 100ps

module testbench;

  // pack_method settings and bit positions
  localparam logic [1:0] M_RAW    = 2'd0;
  localparam logic [1:0] M_RLE    = 2'd1;
  localparam logic [1:0] M_LZ     = 2'd2;
  localparam logic [1:0] M_LZ_RLE = 2'd3;
  localparam int RLE_BIT = 0;
  localparam int LZ_BIT  = 1;

  localparam int SETTLE     = 48;      // longest word is a pair high byte
  localparam int LONG_HOLD  = 400;
  localparam int RAND_WORDS = 180;
  localparam int LIMIT      = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic [6:0] rep;
    logic       last;
  } result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // xd / xrep are only meaningful where typed is set; then exactly one result is due
  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] d;
    logic       eos;
    logic       typed;
    logic [7:0] xd;
    logic [6:0] xrep;
  } row_t;

  localparam row_t DIRECTED [28] = '{
    // reset setting: raw bytes straight through
    '{ROW_WORD, 8'h00, 1'b0, 1'b1, 8'h00, 7'd1},
    '{ROW_WORD, 8'hFF, 1'b1, 1'b1, 8'hFF, 7'd1},
    // run-length only: repeat, empty header, pass-through, longest repeat
    '{ROW_CFG,  8'(M_RLE), 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h03, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'hA5, 1'b0, 1'b1, 8'hA5, 7'd3},
    '{ROW_WORD, 8'h00, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h82, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h11, 1'b0, 1'b1, 8'h11, 7'd1},
    '{ROW_WORD, 8'h22, 1'b0, 1'b1, 8'h22, 7'd1},
    '{ROW_WORD, 8'h7F, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h5A, 1'b1, 1'b1, 8'h5A, 7'd127},
    // window only: literal, longest overlapping copy, literal closing the stream
    '{ROW_CFG,  8'(M_LZ), 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h02, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h41, 1'b0, 1'b1, 8'h41, 7'd1},
    '{ROW_WORD, 8'h00, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'hF0, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h42, 1'b1, 1'b1, 8'h42, 7'd1},
    // pair cut off by end of stream
    '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h34, 1'b1, 1'b0, 8'h00, 7'd0},
    // farthest distance, shortest copy, wrapping the window
    '{ROW_WORD, 8'h01, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'hFF, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h0F, 1'b1, 1'b0, 8'h00, 7'd0},
    // both stages: literals feed run-length headers
    '{ROW_CFG,  8'(M_LZ_RLE), 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h00, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h81, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h77, 1'b0, 1'b1, 8'h77, 7'd1},
    '{ROW_WORD, 8'h05, 1'b0, 1'b0, 8'h00, 7'd0},
    '{ROW_WORD, 8'h99, 1'b1, 1'b1, 8'h99, 7'd5}
  };

  localparam logic [1:0] PHASE_START [4] = '{M_LZ_RLE, M_RAW, M_LZ, M_RLE};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] out_byte, [14:8] repeat_count, [15] zero
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'd0;

  lz77_rle_byte_decompressor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // decoder shadow state
  logic [7:0]                 hist [lzr_pkg::WIN_DEPTH];
  logic [lzr_pkg::WIN_AW-1:0] wr_pos;
  logic [7:0]                 flags;
  logic [7:0]                 flag_bit;
  logic [7:0]                 pair_lo;
  logic                       pair_wait;
  logic [7:0]                 rle_cnt;
  logic [1:0]                 method;

  result_t step_q [$];     // results of the word being decoded
  result_t pending_q [$];  // results still owed by the block

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    errors++;
  endtask

  function automatic void clear_stream();
    wr_pos = '0;
    flags = 8'h00;
    flag_bit = 8'h00;
    pair_lo = 8'h00;
    pair_wait = 1'b0;
    rle_cnt = 8'h00;
  endfunction

  // run-length stage: a header with top bit clear repeats the next byte,
  // with top bit set it lets the next (header & 0x7f) bytes pass
  function automatic void rle_feed(input logic [7:0] v);
    if (!method[RLE_BIT]) begin
      step_q.push_back(result_t'{v, 7'd1, 1'b0});
    end else if (rle_cnt[6:0] != 7'd0) begin
      if (rle_cnt[7]) begin
        step_q.push_back(result_t'{v, 7'd1, 1'b0});
        rle_cnt = rle_cnt - 8'd1;
      end else begin
        step_q.push_back(result_t'{v, rle_cnt[6:0], 1'b0});
        rle_cnt = 8'h00;
      end
    end else begin
      rle_cnt = v;
    end
  endfunction

  function automatic void window_put(input logic [7:0] v);
    hist[wr_pos] = v;
    wr_pos = wr_pos + 12'd1;
    rle_feed(v);
  endfunction

  function automatic void decode_word(input logic [7:0] d, input logic eos);
    logic [15:0]                pair;
    logic [lzr_pkg::WIN_AW-1:0] src;
    int                         len;
    step_q.delete();
    if (!method[LZ_BIT]) begin
      rle_feed(d);
    end else if (pair_wait) begin
      // copy serially so an overlapping source sees bytes just written
      pair = {d, pair_lo};
      len = int'(pair[15:12]) + int'(lzr_pkg::LEN_BIAS);
      src = wr_pos - pair[11:0] - 12'd1;
      for (int i = 0; i < len; i++) begin
        window_put(hist[src]);
        src = src + 12'd1;
      end
      pair_wait = 1'b0;
      pair_lo = 8'h00;
      flag_bit = flag_bit << 1;
    end else if (flag_bit == 8'h00) begin
      flags = d;
      flag_bit = 8'h01;
    end else if ((flags & flag_bit) != 8'h00) begin
      // a low byte arriving with end of stream is dropped
      if (!eos) begin
        pair_lo = d;
        pair_wait = 1'b1;
      end
    end else begin
      window_put(d);
      flag_bit = flag_bit << 1;
    end
    if (step_q.size() != 0)
      step_q[step_q.size() - 1].last = 1'b1;
    if (eos)
      clear_stream();
  endfunction

  function automatic logic [7:0] rle_header();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'(8'h80 | $urandom_range(1, 5));
      2:       return 8'($urandom_range(1, 127));
      3:       return 8'h7F;
      4:       return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  // mostly well-formed words for whatever the decoder awaits, some noise
  task automatic next_word(output logic [7:0] d, output logic eos);
    eos = ($urandom_range(0, 29) == 0);
    if ($urandom_range(0, 9) == 0)
      d = 8'($urandom_range(0, 255));
    else if (method[LZ_BIT] && pair_wait)
      // high byte: length nibble, distance top nibble mostly zero
      d = {4'($urandom_range(0, 15)),
           ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'h0};
    else if (method[LZ_BIT] && (flag_bit == 8'h00 || (flags & flag_bit) != 8'h00))
      d = 8'($urandom_range(0, 255));
    else if (method[RLE_BIT] && rle_cnt[6:0] == 7'd0)
      d = rle_header();
    else
      d = 8'($urandom_range(0, 255));
  endtask

  task automatic drive_word(input logic [7:0] d, input logic eos, input logic typed,
                            input logic [7:0] xd, input logic [6:0] xrep);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    decode_word(d, eos);
    if (typed) begin
      step_q.delete();
      step_q.push_back(result_t'{xd, xrep, 1'b1});
    end
    foreach (step_q[i])
      pending_q.push_back(step_q[i]);
  endtask

  // only touch the register once the block has drained
  task automatic write_method(input logic [1:0] m);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    method = m;
    burst_left = 0;
  endtask

  // result side: check each word, then pick the next ready value
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_tdata));
      end else begin
        want = pending_q.pop_front();
        if (out_tdata[7:0] != want.data)
          report_mismatch($sformatf("out_byte %h, expected %h", out_tdata[7:0], want.data));
        if (out_tdata[14:8] != want.rep)
          report_mismatch($sformatf("repeat_count %0d, expected %0d",
                                    out_tdata[14:8], want.rep));
        if (out_tlast != want.last)
          report_mismatch($sformatf("last %b, expected %b", out_tlast, want.last));
        if (out_tdata[15] !== 1'b0)
          report_mismatch("padding bit of out_tdata not zero");
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(40, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= (rx_left % 4 == 0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("lz77_rle_byte_decompressor_core: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] d;
    logic       eos;
    int         sent;
    int         count;
    int         phase;
    row_t       row;

    for (int i = 0; i < lzr_pkg::WIN_DEPTH; i++)
      hist[i] = 8'h00;
    clear_stream();
    method = M_RAW;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; the window clear after reset just holds off the first word
    for (int r = 0; r < $size(DIRECTED); r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_CFG)
        write_method(row.d[1:0]);
      else
        drive_word(row.d, row.eos, row.typed, row.xd, row.xrep);
    end

    // random phases, each under its own setting
    sent = 0;
    phase = 0;
    while (sent < RAND_WORDS) begin
      write_method((phase < 4) ? PHASE_START[phase] : 2'($urandom_range(0, 3)));
      if (phase == 2)
        hold_req = 1'b1;  // results back up while words keep coming
      count = $urandom_range(20, 35);
      for (int i = 0; i < count; i++) begin
        next_word(d, eos);
        drive_word(d, eos, 1'b0, 8'h00, 7'd0);
        sent++;
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0)
      $display("lz77_rle_byte_decompressor_core: match");
    else
      $display("lz77_rle_byte_decompressor_core: mismatch");
    $finish;
  end

endmodule
